// ===== hw/rtl/mbdm_pkg.sv =====
// Shared types and constants for the dual motor drive poll master.
package mbdm_pkg;

  // Frame geometry and CRC-16 constants
  localparam int unsigned FRAME_BYTES_DEF = 13;
  localparam int unsigned CRC_BITS        = 8;
  localparam logic [15:0] CRC_INIT_VAL    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  // Fixed frame bytes of a write-multiple-registers request
  localparam logic [7:0] FUNC_WRITE_MULTI = 8'h10;
  localparam logic [7:0] START_REG_HI     = 8'h03;
  localparam logic [7:0] START_REG_LO     = 8'hE8;
  localparam logic [7:0] QTY_HI           = 8'h00;
  localparam logic [7:0] QTY_LO           = 8'h02;
  localparam logic [7:0] BYTE_COUNT       = 8'h04;
  localparam logic [7:0] CURRENT_LIMIT    = 8'h00;

  // Speed clamp limits
  localparam logic signed [15:0] SPEED_MAX = 16'sd255;
  localparam logic signed [15:0] SPEED_MIN = -16'sd255;

  // Config port widths
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLL_PERIOD   = 4'd0,
    REG_REPLY_TIMEOUT = 4'd1,
    REG_LEFT_ADDR     = 4'd2,
    REG_RIGHT_ADDR    = 4'd3,
    REG_CODE_FWD      = 4'd4,
    REG_CODE_BWD      = 4'd5,
    REG_CODE_STOP     = 4'd6,
    REG_BUS_MODE      = 4'd7
  } cfg_reg_e;

  // Polling phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SEND_L = 3'd1,
    PH_WAIT_L = 3'd2,
    PH_SEND_R = 3'd3,
    PH_WAIT_R = 3'd4
  } phase_e;

  // Frame sequencer states
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_DECIDE,
    SQ_BYTE,
    SQ_SHIFT,
    SQ_CRC_LO,
    SQ_CRC_HI
  } seq_state_e;

  // CRC unit operations
  typedef enum logic [1:0] {
    CRC_HOLD,
    CRC_LOAD,
    CRC_XOR,
    CRC_SHIFT
  } crc_op_e;

  // Source of the next result beat
  typedef enum logic [1:0] {
    SRC_STATUS,
    SRC_FRAME,
    SRC_CRC_LO,
    SRC_CRC_HI
  } out_src_e;

  // Event left by the last accepted item
  typedef struct packed {
    logic send;
    logic clr;
  } poll_ev_t;

endpackage

// ===== hw/rtl/mbdm_if.sv =====
// Handshake channel interfaces: input items, result items, config writes.
interface mbdm_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic               reply_ready;

  modport source (output valid, mode, left_speed, right_speed, reply_ready, input ready);
  modport sink   (input valid, mode, left_speed, right_speed, reply_ready, output ready);
endinterface

interface mbdm_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tx_byte;
  logic        tx_valid;
  logic        tx_last;
  logic        rx_clear;
  logic [2:0]  phase;
  logic [15:0] dropped_left;
  logic [15:0] dropped_right;

  modport source (output valid, tx_byte, tx_valid, tx_last, rx_clear, phase, dropped_left,
                  dropped_right, input ready);
  modport sink   (input valid, tx_byte, tx_valid, tx_last, rx_clear, phase, dropped_left,
                  dropped_right, output ready);
endinterface

interface mbdm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mbdm_pkg::CFG_IDX_W-1:0]      index;
  logic [mbdm_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mbdm_crc.sv =====
// Bit-serial CRC-16 unit shared across all data bytes of a frame.
module mbdm_crc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mbdm_pkg::crc_op_e op_i,
  input  logic [7:0]        byte_i,
  output logic [15:0]       crc_o
);

  logic [15:0] crc_q, crc_d;

  // Apply one operation per cycle
  always_comb begin
    crc_d = crc_q;
    case (op_i)
      mbdm_pkg::CRC_LOAD:  crc_d = mbdm_pkg::CRC_INIT_VAL;
      mbdm_pkg::CRC_XOR:   crc_d = crc_q ^ {8'h00, byte_i};
      mbdm_pkg::CRC_SHIFT: begin
        if (crc_q[0]) begin
          crc_d = (crc_q >> 1) ^ mbdm_pkg::CRC_POLY;
        end else begin
          crc_d = crc_q >> 1;
        end
      end
      default: crc_d = crc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= mbdm_pkg::CRC_INIT_VAL;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

// ===== hw/rtl/mbdm_poll.sv =====
// Poll phase tracker: targets, millisecond timer, phase and drop counters.
module mbdm_poll (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_i,
  input  logic                set_i,
  input  logic signed [15:0]  left_speed_i,
  input  logic signed [15:0]  right_speed_i,
  input  logic                reply_ready_i,
  input  logic [15:0]         poll_period_i,
  input  logic [15:0]         reply_timeout_i,
  output mbdm_pkg::phase_e    phase_o,
  output logic signed [8:0]   target_left_o,
  output logic signed [8:0]   target_right_o,
  output logic [15:0]         drops_left_o,
  output logic [15:0]         drops_right_o,
  output mbdm_pkg::poll_ev_t  ev_o
);

  mbdm_pkg::phase_e   phase_q, phase_d;
  logic [15:0]        elapsed_q, elapsed_d, elapsed_inc;
  logic signed [8:0]  tgt_l_q, tgt_l_d, tgt_r_q, tgt_r_d;
  logic [15:0]        drops_l_q, drops_l_d, drops_r_q, drops_r_d;
  mbdm_pkg::poll_ev_t ev_q, ev_d;

  function automatic logic signed [8:0] clamp_speed(input logic signed [15:0] v);
    logic signed [8:0] r;
    if (v > mbdm_pkg::SPEED_MAX) begin
      r = mbdm_pkg::SPEED_MAX[8:0];
    end else if (v < mbdm_pkg::SPEED_MIN) begin
      r = mbdm_pkg::SPEED_MIN[8:0];
    end else begin
      r = v[8:0];
    end
    return r;
  endfunction

  // Saturate the timer
  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

  // Advance the phase on a tick, update targets on a set
  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    tgt_l_d   = tgt_l_q;
    tgt_r_d   = tgt_r_q;
    drops_l_d = drops_l_q;
    drops_r_d = drops_r_q;
    ev_d      = ev_q;
    if (set_i) begin
      tgt_l_d = clamp_speed(left_speed_i);
      tgt_r_d = clamp_speed(right_speed_i);
      ev_d    = '{send: 1'b0, clr: 1'b0};
    end else if (tick_i) begin
      elapsed_d = elapsed_inc;
      ev_d      = '{send: 1'b0, clr: 1'b0};
      case (phase_q)
        mbdm_pkg::PH_SEND_L: begin
          phase_d   = mbdm_pkg::PH_WAIT_L;
          elapsed_d = '0;
          ev_d.send = 1'b1;
        end
        mbdm_pkg::PH_WAIT_L: begin
          if (reply_ready_i) begin
            ev_d.clr = 1'b1;
            phase_d  = mbdm_pkg::PH_SEND_R;
          end else if (elapsed_inc >= reply_timeout_i) begin
            drops_l_d = drops_l_q + 16'd1;
            phase_d   = mbdm_pkg::PH_SEND_R;
          end
        end
        mbdm_pkg::PH_SEND_R: begin
          phase_d   = mbdm_pkg::PH_WAIT_R;
          elapsed_d = '0;
          ev_d.send = 1'b1;
        end
        mbdm_pkg::PH_WAIT_R: begin
          if (reply_ready_i) begin
            ev_d.clr = 1'b1;
            phase_d  = mbdm_pkg::PH_IDLE;
          end else if (elapsed_inc >= reply_timeout_i) begin
            drops_r_d = drops_r_q + 16'd1;
            phase_d   = mbdm_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_d = mbdm_pkg::PH_IDLE;
          if (elapsed_inc >= poll_period_i) begin
            elapsed_d = '0;
            phase_d   = mbdm_pkg::PH_SEND_L;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mbdm_pkg::PH_IDLE;
      elapsed_q <= '0;
      tgt_l_q   <= '0;
      tgt_r_q   <= '0;
      drops_l_q <= '0;
      drops_r_q <= '0;
      ev_q      <= '{send: 1'b0, clr: 1'b0};
    end else begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      tgt_l_q   <= tgt_l_d;
      tgt_r_q   <= tgt_r_d;
      drops_l_q <= drops_l_d;
      drops_r_q <= drops_r_d;
      ev_q      <= ev_d;
    end
  end

  assign phase_o        = phase_q;
  assign target_left_o  = tgt_l_q;
  assign target_right_o = tgt_r_q;
  assign drops_left_o   = drops_l_q;
  assign drops_right_o  = drops_r_q;
  assign ev_o           = ev_q;

endmodule

// ===== hw/rtl/modbus_dual_motor_poll_master_core.sv =====
// A set or non-send tick offers its single status beat, loaded from the DECIDE state into
// the output register once the output is free; then the next item can be taken.
// A send tick emits FRAME_BYTES beats; the CRC unit shifts one bit a cycle, so each of the
// FRAME_BYTES-2 data bytes passes a BYTE state and then the SHIFT state once per bit.
// Input is busy until the CRC_HI beat loads; output stalls hold BYTE, CRC_LO and CRC_HI.
// Reset (rst_ni low, asynchronous): phase idle, timer, targets and drop counters zero,
// CRC all ones, config registers at their defaults.
module modbus_dual_motor_poll_master_core #(
  parameter int unsigned FRAME_BYTES = mbdm_pkg::FRAME_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mbdm_in_if.sink  in_i,
  mbdm_out_if.source out_o,
  mbdm_cfg_if.sink cfg_i
);

  localparam int unsigned DATA_BYTES = FRAME_BYTES - 2;
  localparam int unsigned IDX_W      = $clog2(FRAME_BYTES);
  localparam int unsigned BIT_W      = $clog2(mbdm_pkg::CRC_BITS);

  // Config registers
  logic [15:0] poll_period_q, reply_timeout_q;
  logic [7:0]  left_addr_q, right_addr_q, code_fwd_q, code_bwd_q, code_stop_q, bus_mode_q;

  // Sequencer and datapath
  mbdm_pkg::seq_state_e state_q, state_d;
  logic [IDX_W-1:0]     idx_q;
  logic [BIT_W-1:0]     bit_q;
  logic [7:0]           addr_q, dir_q, mag_q;
  logic                 in_ready, out_free, out_load, frame_setup, idx_clr, idx_inc, bit_inc;
  mbdm_pkg::out_src_e   out_src;
  mbdm_pkg::crc_op_e    crc_op;
  logic [7:0]           cur_byte;
  logic [15:0]          crc;
  logic                 in_fire;
  logic                 bit_last, idx_last;

  // Poll state
  mbdm_pkg::phase_e     phase;
  logic signed [8:0]    tgt_l, tgt_r, tgt_sel, tgt_neg;
  logic [15:0]          drops_l, drops_r;
  mbdm_pkg::poll_ev_t   ev;

  // Output register
  logic        ov_q;
  logic [7:0]  o_byte_q;
  logic        o_txv_q, o_last_q, o_clr_q;
  logic [2:0]  o_phase_q;
  logic [15:0] o_dl_q, o_dr_q;

  function automatic logic [7:0] frame_byte(input logic [IDX_W-1:0] i, input logic [7:0] a,
                                            input logic [7:0] m, input logic [7:0] d,
                                            input logic [7:0] g);
    logic [7:0] r;
    case (i)
      IDX_W'(0): r = a;
      IDX_W'(1): r = mbdm_pkg::FUNC_WRITE_MULTI;
      IDX_W'(2): r = mbdm_pkg::START_REG_HI;
      IDX_W'(3): r = mbdm_pkg::START_REG_LO;
      IDX_W'(4): r = mbdm_pkg::QTY_HI;
      IDX_W'(5): r = mbdm_pkg::QTY_LO;
      IDX_W'(6): r = mbdm_pkg::BYTE_COUNT;
      IDX_W'(7): r = m;
      IDX_W'(8): r = d;
      IDX_W'(9): r = g;
      default:   r = mbdm_pkg::CURRENT_LIMIT;
    endcase
    return r;
  endfunction

  // Take config writes at any time
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_period_q   <= 16'd20;
      reply_timeout_q <= 16'd10;
      left_addr_q     <= 8'd1;
      right_addr_q    <= 8'd2;
      code_fwd_q      <= 8'd1;
      code_bwd_q      <= 8'd2;
      code_stop_q     <= 8'd0;
      bus_mode_q      <= 8'd2;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mbdm_pkg::REG_POLL_PERIOD:   poll_period_q   <= cfg_i.data;
        mbdm_pkg::REG_REPLY_TIMEOUT: reply_timeout_q <= cfg_i.data;
        mbdm_pkg::REG_LEFT_ADDR:     left_addr_q     <= cfg_i.data[7:0];
        mbdm_pkg::REG_RIGHT_ADDR:    right_addr_q    <= cfg_i.data[7:0];
        mbdm_pkg::REG_CODE_FWD:      code_fwd_q      <= cfg_i.data[7:0];
        mbdm_pkg::REG_CODE_BWD:      code_bwd_q      <= cfg_i.data[7:0];
        mbdm_pkg::REG_CODE_STOP:     code_stop_q     <= cfg_i.data[7:0];
        mbdm_pkg::REG_BUS_MODE:      bus_mode_q      <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;

  mbdm_poll u_poll (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tick_i          (in_fire && !in_i.mode),
    .set_i           (in_fire && in_i.mode),
    .left_speed_i    (in_i.left_speed),
    .right_speed_i   (in_i.right_speed),
    .reply_ready_i   (in_i.reply_ready),
    .poll_period_i   (poll_period_q),
    .reply_timeout_i (reply_timeout_q),
    .phase_o         (phase),
    .target_left_o   (tgt_l),
    .target_right_o  (tgt_r),
    .drops_left_o    (drops_l),
    .drops_right_o   (drops_r),
    .ev_o            (ev)
  );

  mbdm_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (crc_op),
    .byte_i (cur_byte),
    .crc_o  (crc)
  );

  assign out_free = !ov_q || out_o.ready;
  assign bit_last = (bit_q == BIT_W'(mbdm_pkg::CRC_BITS - 1));
  assign idx_last = (idx_q == IDX_W'(DATA_BYTES - 1));
  assign cur_byte = frame_byte(idx_q, addr_q, bus_mode_q, dir_q, mag_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mbdm_pkg::SQ_IDLE:   if (in_fire) state_d = mbdm_pkg::SQ_DECIDE;
      mbdm_pkg::SQ_DECIDE: begin
        if (ev.send) begin
          state_d = mbdm_pkg::SQ_BYTE;
        end else if (out_free) begin
          state_d = mbdm_pkg::SQ_IDLE;
        end
      end
      mbdm_pkg::SQ_BYTE:   if (out_free) state_d = mbdm_pkg::SQ_SHIFT;
      mbdm_pkg::SQ_SHIFT: begin
        if (bit_last) begin
          state_d = idx_last ? mbdm_pkg::SQ_CRC_LO : mbdm_pkg::SQ_BYTE;
        end
      end
      mbdm_pkg::SQ_CRC_LO: if (out_free) state_d = mbdm_pkg::SQ_CRC_HI;
      mbdm_pkg::SQ_CRC_HI: if (out_free) state_d = mbdm_pkg::SQ_IDLE;
      default:             state_d = mbdm_pkg::SQ_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    out_load    = 1'b0;
    out_src     = mbdm_pkg::SRC_STATUS;
    crc_op      = mbdm_pkg::CRC_HOLD;
    frame_setup = 1'b0;
    idx_clr     = 1'b0;
    idx_inc     = 1'b0;
    bit_inc     = 1'b0;
    case (state_q)
      mbdm_pkg::SQ_IDLE: in_ready = 1'b1;
      mbdm_pkg::SQ_DECIDE: begin
        if (ev.send) begin
          crc_op      = mbdm_pkg::CRC_LOAD;
          frame_setup = 1'b1;
          idx_clr     = 1'b1;
        end else begin
          out_load = out_free;
        end
      end
      mbdm_pkg::SQ_BYTE: begin
        out_src = mbdm_pkg::SRC_FRAME;
        if (out_free) begin
          out_load = 1'b1;
          crc_op   = mbdm_pkg::CRC_XOR;
        end
      end
      mbdm_pkg::SQ_SHIFT: begin
        crc_op  = mbdm_pkg::CRC_SHIFT;
        bit_inc = 1'b1;
        idx_inc = bit_last && !idx_last;
      end
      mbdm_pkg::SQ_CRC_LO: begin
        out_src  = mbdm_pkg::SRC_CRC_LO;
        out_load = out_free;
      end
      mbdm_pkg::SQ_CRC_HI: begin
        out_src  = mbdm_pkg::SRC_CRC_HI;
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbdm_pkg::SQ_IDLE;
      idx_q   <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      if (idx_clr) begin
        idx_q <= '0;
      end else if (idx_inc) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (out_load) begin
        bit_q <= '0;
      end else if (bit_inc) begin
        bit_q <= bit_q + BIT_W'(1);
      end
    end
  end

  // Pick the side just scheduled and form direction and magnitude
  assign tgt_sel = (phase == mbdm_pkg::PH_WAIT_R) ? tgt_r : tgt_l;
  assign tgt_neg = -tgt_sel;

  always_ff @(posedge clk_i) begin
    if (frame_setup) begin
      addr_q <= (phase == mbdm_pkg::PH_WAIT_R) ? right_addr_q : left_addr_q;
      if (tgt_sel > 9'sd0) begin
        dir_q <= code_fwd_q;
        mag_q <= tgt_sel[7:0];
      end else if (tgt_sel < 9'sd0) begin
        dir_q <= code_bwd_q;
        mag_q <= tgt_neg[7:0];
      end else begin
        dir_q <= code_stop_q;
        mag_q <= 8'h00;
      end
    end
  end

  // Hold a result beat until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_phase_q <= phase;
      o_dl_q    <= drops_l;
      o_dr_q    <= drops_r;
      case (out_src)
        mbdm_pkg::SRC_FRAME: begin
          o_byte_q <= cur_byte;
          o_txv_q  <= 1'b1;
          o_last_q <= 1'b0;
          o_clr_q  <= (idx_q == '0);
        end
        mbdm_pkg::SRC_CRC_LO: begin
          o_byte_q <= crc[7:0];
          o_txv_q  <= 1'b1;
          o_last_q <= 1'b0;
          o_clr_q  <= 1'b0;
        end
        mbdm_pkg::SRC_CRC_HI: begin
          o_byte_q <= crc[15:8];
          o_txv_q  <= 1'b1;
          o_last_q <= 1'b1;
          o_clr_q  <= 1'b0;
        end
        default: begin
          o_byte_q <= 8'h00;
          o_txv_q  <= 1'b0;
          o_last_q <= 1'b1;
          o_clr_q  <= ev.clr;
        end
      endcase
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.tx_byte       = o_byte_q;
  assign out_o.tx_valid      = o_txv_q;
  assign out_o.tx_last       = o_last_q;
  assign out_o.rx_clear      = o_clr_q;
  assign out_o.phase         = o_phase_q;
  assign out_o.dropped_left  = o_dl_q;
  assign out_o.dropped_right = o_dr_q;

endmodule
